// ===== hdl/quaternion_vector_rotate_top_defines.svh =====
// Assertion helpers used by the RTL top level.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define QVR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define QVR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qvr_pkg.sv =====
`timescale 1ns / 1ps

package qvr_pkg;

    // Quaternion parts are signed Q2.14.
    localparam int QUAT_W = 16;

    typedef enum logic [1:0] {
        CFG_QUAT_W = 2'd0,
        CFG_QUAT_X = 2'd1,
        CFG_QUAT_Y = 2'd2,
        CFG_QUAT_Z = 2'd3
    } cfg_idx_t;

    // Load enables of the two register stages inside a round/saturate unit.
    typedef struct packed {
        logic sum_en;
        logic sat_en;
    } qvr_en_t;

endpackage

// ===== hdl/quaternion_vector_rotate_top.sv =====
// Quaternion vector rotation: each request (s_vec_x/y/z) is rotated by the
// quaternion held in the four Q2.14 registers (reset to identity), computing
// q * (0, v) * conj(q). Both Hamilton products are summed exactly and rounded
// half up at FRAC_BITS; the intermediate is clipped to VEC_WIDTH+2 bits and the
// result to VEC_WIDTH bits, and m_saturated flags any clipping in that request.
// A quaternion that is not of unit length scales the vector by its squared
// norm. The pipeline accepts one request per clock while no full stage is
// blocked, and passes it through six register stages: multiply, sum,
// round/clip for the first product, and the same three stages for the second,
// built around 24 parallel multipliers of 16 by at most VEC_WIDTH+2 bits. Each
// stage stalls only when full and its successor is blocked, so bubbles collapse
// under m_ready backpressure. Write the quaternion registers only while the
// pipeline is empty.
`timescale 1ns / 1ps

`include "quaternion_vector_rotate_top_defines.svh"

module quaternion_vector_rotate_top #(
    parameter int VEC_WIDTH = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [qvr_pkg::QUAT_W-1:0]   cfg_wdata,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VEC_WIDTH-1:0]  s_vec_x,
    input  logic signed [VEC_WIDTH-1:0]  s_vec_y,
    input  logic signed [VEC_WIDTH-1:0]  s_vec_z,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VEC_WIDTH-1:0]  m_rot_x,
    output logic signed [VEC_WIDTH-1:0]  m_rot_y,
    output logic signed [VEC_WIDTH-1:0]  m_rot_z,
    output logic                         m_saturated
);
    import qvr_pkg::*;

    localparam int MID_W   = VEC_WIDTH + 2;       // width of q * (0, v)
    localparam int P1_W    = VEC_WIDTH + QUAT_W;  // first product terms
    localparam int P2_W    = MID_W + QUAT_W;      // second product terms
    localparam int NSTAGE  = 6;
    localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(64'd1 << FRAC_BITS);

    // Quaternion registers.
    logic signed [QUAT_W-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;

    // Stage valid bits and backward ready chain.
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE:0]   rdy;

    // Stage 1: products of q and v, grouped by component of t (w, x, y, z).
    logic signed [P1_W-1:0] p1_reg [4][3];
    // Stages 2-3: t = q * (0, v), clipped.
    logic signed [MID_W-1:0] t_mid [4];
    logic [3:0]              mid_sat;
    // Stage 4: products of t and conj(q), grouped by result component.
    logic signed [P2_W-1:0] p2_reg [3][4];
    logic                   sat_p2_reg;
    // Stage 5-6: result.
    logic                   sat_s5_reg;
    logic                   sat_out_reg;
    logic signed [VEC_WIDTH-1:0] rot [3];
    logic [2:0]             rot_sat;

    qvr_en_t mid_en, out_en;

    // ------------------------------------------------------------------
    // Configuration: take writes directly, no read-back.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_w_reg <= QUAT_ONE;
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_QUAT_W: quat_w_reg <= cfg_wdata;
                CFG_QUAT_X: quat_x_reg <= cfg_wdata;
                CFG_QUAT_Y: quat_y_reg <= cfg_wdata;
                CFG_QUAT_Z: quat_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor moves.
    // ------------------------------------------------------------------
    always_comb begin
        rdy[NSTAGE] = m_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: twelve products of q and the request vector.
    // tw = -qx*vx - qy*vy - qz*vz
    // tx =  qw*vx + qy*vz - qz*vy
    // ty =  qw*vy + qz*vx - qx*vz
    // tz =  qw*vz + qx*vy - qy*vx
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            p1_reg[0][0] <= quat_x_reg * s_vec_x;
            p1_reg[0][1] <= quat_y_reg * s_vec_y;
            p1_reg[0][2] <= quat_z_reg * s_vec_z;
            p1_reg[1][0] <= quat_w_reg * s_vec_x;
            p1_reg[1][1] <= quat_y_reg * s_vec_z;
            p1_reg[1][2] <= quat_z_reg * s_vec_y;
            p1_reg[2][0] <= quat_w_reg * s_vec_y;
            p1_reg[2][1] <= quat_z_reg * s_vec_x;
            p1_reg[2][2] <= quat_x_reg * s_vec_z;
            p1_reg[3][0] <= quat_w_reg * s_vec_z;
            p1_reg[3][1] <= quat_x_reg * s_vec_y;
            p1_reg[3][2] <= quat_y_reg * s_vec_x;
        end
    end

    // Stages 2-3: sum, round and clip each component of t.
    assign mid_en.sum_en = rdy[1];
    assign mid_en.sat_en = rdy[2];

    for (genvar g = 0; g < 4; g++) begin : g_mid
        qvr_rsat #(
            .IN_W      (P1_W),
            .N_TERMS   (3),
            .SUB_MASK  ((g == 0) ? 3'b111 : 3'b100),
            .OUT_W     (MID_W),
            .FRAC_BITS (FRAC_BITS)
        ) u_rsat (
            .aclk (aclk),
            .en   (mid_en),
            .term (p1_reg[g]),
            .res  (t_mid[g]),
            .sat  (mid_sat[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 4: twelve products of t and q for the vector part of t*conj(q).
    // rx = -tw*qx + tx*qw - ty*qz + tz*qy
    // ry = -tw*qy + ty*qw - tz*qx + tx*qz
    // rz = -tw*qz + tz*qw - tx*qy + ty*qx
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            p2_reg[0][0] <= t_mid[0] * quat_x_reg;
            p2_reg[0][1] <= t_mid[1] * quat_w_reg;
            p2_reg[0][2] <= t_mid[2] * quat_z_reg;
            p2_reg[0][3] <= t_mid[3] * quat_y_reg;
            p2_reg[1][0] <= t_mid[0] * quat_y_reg;
            p2_reg[1][1] <= t_mid[2] * quat_w_reg;
            p2_reg[1][2] <= t_mid[3] * quat_x_reg;
            p2_reg[1][3] <= t_mid[1] * quat_z_reg;
            p2_reg[2][0] <= t_mid[0] * quat_z_reg;
            p2_reg[2][1] <= t_mid[3] * quat_w_reg;
            p2_reg[2][2] <= t_mid[1] * quat_y_reg;
            p2_reg[2][3] <= t_mid[2] * quat_x_reg;
            sat_p2_reg   <= |mid_sat;
        end
        if (rdy[4]) begin
            sat_s5_reg <= sat_p2_reg;
        end
        if (rdy[5]) begin
            sat_out_reg <= sat_s5_reg;
        end
    end

    // Stages 5-6: sum, round and clip each result component.
    assign out_en.sum_en = rdy[4];
    assign out_en.sat_en = rdy[5];

    for (genvar g = 0; g < 3; g++) begin : g_out
        qvr_rsat #(
            .IN_W      (P2_W),
            .N_TERMS   (4),
            .SUB_MASK  (4'b0101),
            .OUT_W     (VEC_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_rsat (
            .aclk (aclk),
            .en   (out_en),
            .term (p2_reg[g]),
            .res  (rot[g]),
            .sat  (rot_sat[g])
        );
    end

    // Result channel.
    assign m_valid     = vld_reg[NSTAGE-1];
    assign m_rot_x     = rot[0];
    assign m_rot_y     = rot[1];
    assign m_rot_z     = rot[2];
    assign m_saturated = sat_out_reg | (|rot_sat);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A full pipeline facing a blocked consumer must refuse new requests.
    `QVR_ASSERT_NOW(a_full_stall, aclk, aresetn, (&vld_reg) && !m_ready, !s_ready, "full pipeline accepted a request")
    // Backpressure at the input only comes from an occupied first stage.
    `QVR_ASSERT_NOW(a_ready_src, aclk, aresetn, !s_ready, vld_reg[0], "input stalled with empty first stage")
    // An accepted request lands in the first stage.
    `QVR_ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, vld_reg[0], "accepted request lost")
    // A blocked intermediate stage holds its clipped value.
    `QVR_ASSERT_NEXT(a_mid_hold, aclk, aresetn, vld_reg[2] && !rdy[3], $stable(t_mid[1]), "stalled intermediate changed")

endmodule

// ===== hdl/qvr_rsat.sv =====
`timescale 1ns / 1ps

module qvr_rsat #(
    parameter int IN_W      = 32,
    parameter int N_TERMS   = 3,
    parameter logic [N_TERMS-1:0] SUB_MASK = '0,
    parameter int OUT_W     = 18,
    parameter int FRAC_BITS = 14
) (
    input  logic                   aclk,
    input  qvr_pkg::qvr_en_t       en,
    input  logic signed [IN_W-1:0] term [N_TERMS],
    output logic signed [OUT_W-1:0] res,
    output logic                   sat
);
    import qvr_pkg::*;

    localparam int BASE_W = (IN_W + 2 > FRAC_BITS + 1) ? IN_W + 2 : FRAC_BITS + 1;
    localparam int SUM_W  = BASE_W + 1;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(64'd1 << (FRAC_BITS - 1));

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-OUT_W:0]     hi_bits;
    logic                     ovf;
    logic signed [OUT_W-1:0]  res_next;
    logic signed [OUT_W-1:0]  res_reg;
    logic                     sat_reg;

    // Exact signed sum plus half an LSB of the result.
    always_comb begin
        logic signed [SUM_W-1:0] ext;
        sum_next = RND;
        for (int i = 0; i < N_TERMS; i++) begin
            ext = SUM_W'(term[i]);
            if (SUB_MASK[i]) begin
                sum_next = sum_next - ext;
            end else begin
                sum_next = sum_next + ext;
            end
        end
    end

    // Floor shift, then clip to the output range.
    always_comb begin
        shifted = sum_reg >>> FRAC_BITS;
        hi_bits = shifted[SUM_W-1:OUT_W-1];
        ovf     = !((&hi_bits) || (~|hi_bits));
        if (!ovf) begin
            res_next = shifted[OUT_W-1:0];
        end else if (shifted[SUM_W-1]) begin
            res_next = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res_next = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en.sum_en) begin
            sum_reg <= sum_next;
        end
        if (en.sat_en) begin
            res_reg <= res_next;
            sat_reg <= ovf;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// ===== tb/tb_quaternion_vector_rotate_top.sv =====
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate_top;
    import qvr_pkg::*;

    localparam int VEC_W        = 16;
    localparam int FRAC         = 14;
    localparam int MID_W        = VEC_W + 2;
    localparam int Q_ONE        = 1 << FRAC;
    localparam int LATENCY      = 6;
    localparam int DRAIN_CYCLES = 4 * LATENCY;
    localparam int LONG_HOLD    = 80;
    localparam int BLOCK_ITEMS  = 95;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 100;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
        logic                    sat;
    } rot_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } quat_t;

    // One directed request: the quaternion in force, the vector, and, where the
    // answer is obvious, the result typed in by hand.
    typedef struct packed {
        logic signed [QUAT_W-1:0] qw;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
        logic signed [VEC_W-1:0]  vx;
        logic signed [VEC_W-1:0]  vy;
        logic signed [VEC_W-1:0]  vz;
        logic                     typed;
        logic signed [VEC_W-1:0]  ex;
        logic signed [VEC_W-1:0]  ey;
        logic signed [VEC_W-1:0]  ez;
        logic                     esat;
    } dir_row_t;

    localparam int NUM_DIR = 19;

    localparam dir_row_t DIR_ROWS [0:NUM_DIR-1] = '{
        // reset quaternion is the identity: vector passes through unchanged
        '{Q_ONE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{Q_ONE, 0, 0, 0, 32767, -32768, 1, 1, 32767, -32768, 1, 0},
        '{Q_ONE, 0, 0, 0, -32768, 32767, -1, 1, -32768, 32767, -1, 0},
        '{Q_ONE, 0, 0, 0, 12345, -2222, 7, 1, 12345, -2222, 7, 0},
        // zero quaternion collapses everything to zero
        '{0, 0, 0, 0, 32767, 32767, 32767, 1, 0, 0, 0, 0},
        '{0, 0, 0, 0, -32768, -32768, -32768, 1, 0, 0, 0, 0},
        // half turns about each axis; negating -32768 clips at the output
        '{0, 0, 0, Q_ONE, -32768, -32768, 5, 1, 32767, 32767, 5, 1},
        '{0, 0, 0, Q_ONE, 100, -200, 300, 1, -100, 200, 300, 0},
        '{0, Q_ONE, 0, 0, 7, 32767, -32768, 1, 7, -32767, 32767, 1},
        '{0, 0, Q_ONE, 0, -32768, 9, 32767, 1, 32767, 9, -32767, 1},
        // minus identity: same rotation, intermediate swings to +32768
        '{-Q_ONE, 0, 0, 0, -32768, 32767, 123, 1, -32768, 32767, 123, 0},
        // half-length quaternion: ties in the rounding, both signs
        '{8192, 0, 0, 0, 1, -1, 3, 0, 0, 0, 0, 0},
        '{8192, 0, 0, 0, -3, 2, -2, 0, 0, 0, 0, 0},
        // quarter turn about z
        '{11585, 0, 0, 11585, 1000, 0, -1000, 0, 0, 0, 0, 0},
        // norm near 2: vector grows by about 4 and clips
        '{32767, 0, 0, 0, 1000, -1000, 16000, 0, 0, 0, 0, 0},
        // register extremes: intermediate overflow
        '{-32768, -32768, -32768, -32768, -32768, 32767, -32768, 0, 0, 0, 0, 0},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0},
        '{-32768, 32767, -32768, 32767, 32767, -32768, 32767, 0, 0, 0, 0, 0},
        // third of a turn about the main diagonal
        '{8192, 8192, 8192, 8192, 2000, -4000, 6000, 0, 0, 0, 0, 0}
    };

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [1:0]              cfg_index;
    logic [QUAT_W-1:0]       cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [VEC_W-1:0] s_vec_x;
    logic signed [VEC_W-1:0] s_vec_y;
    logic signed [VEC_W-1:0] s_vec_z;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [VEC_W-1:0] m_rot_x;
    logic signed [VEC_W-1:0] m_rot_y;
    logic signed [VEC_W-1:0] m_rot_z;
    logic                    m_saturated;

    // Quaternion the block holds, tracked as it is written.
    quat_t quat_cur;
    // Rotated vectors still owed by the block, oldest first.
    rot_t  pending_rot [$];
    rot_t  got_rot;
    rot_t  want_rot;

    int mismatches    = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    // Long receiver hold-offs asked by the stimulus and granted by the receiver.
    int stall_asked   = 0;
    int stall_granted = 0;

    quaternion_vector_rotate_top #(
        .VEC_WIDTH (VEC_W),
        .FRAC_BITS (FRAC)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_vec_x     (s_vec_x),
        .s_vec_y     (s_vec_y),
        .s_vec_z     (s_vec_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rot_x     (m_rot_x),
        .m_rot_y     (m_rot_y),
        .m_rot_z     (m_rot_z),
        .m_saturated (m_saturated)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Drop the fraction with round half up: floor((s + half) / 2^FRAC).
    function automatic longint round_half_up(input longint s);
        return (s + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clamp_signed(input longint v, input int width);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (width - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Rotate v by q: t = q * (0, v), clipped to MID_W bits, then the vector part
    // of t * conj(q), clipped to VEC_W bits. Any clip raises sat.
    function automatic rot_t rotate_by_quat(input vec_t v, input quat_t q);
        longint qw, qx, qy, qz, vx, vy, vz;
        longint mid_raw [4];
        longint mid [4];
        longint out_raw [3];
        longint out_clip [3];
        rot_t   r;
        qw = q.w;
        qx = q.x;
        qy = q.y;
        qz = q.z;
        vx = v.x;
        vy = v.y;
        vz = v.z;
        r.sat = 1'b0;
        mid_raw[0] = round_half_up(-qx * vx - qy * vy - qz * vz);
        mid_raw[1] = round_half_up(qw * vx + qy * vz - qz * vy);
        mid_raw[2] = round_half_up(qw * vy + qz * vx - qx * vz);
        mid_raw[3] = round_half_up(qw * vz + qx * vy - qy * vx);
        for (int i = 0; i < 4; i++) begin
            mid[i] = clamp_signed(mid_raw[i], MID_W);
            if (mid[i] != mid_raw[i]) r.sat = 1'b1;
        end
        out_raw[0] = round_half_up(-mid[0] * qx + mid[1] * qw - mid[2] * qz + mid[3] * qy);
        out_raw[1] = round_half_up(-mid[0] * qy + mid[2] * qw - mid[3] * qx + mid[1] * qz);
        out_raw[2] = round_half_up(-mid[0] * qz + mid[3] * qw - mid[1] * qy + mid[2] * qx);
        for (int i = 0; i < 3; i++) begin
            out_clip[i] = clamp_signed(out_raw[i], VEC_W);
            if (out_clip[i] != out_raw[i]) r.sat = 1'b1;
        end
        r.x = out_clip[0][VEC_W-1:0];
        r.y = out_clip[1][VEC_W-1:0];
        r.z = out_clip[2][VEC_W-1:0];
        return r;
    endfunction

    // Mostly full-range components, some small ones, some edge values.
    function automatic logic signed [VEC_W-1:0] pick_component();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return VEC_W'($urandom());
        if (sel < 85) return VEC_W'(int'($urandom_range(0, 511)) - 256);
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic vec_t random_vec();
        vec_t v;
        v.x = pick_component();
        v.y = pick_component();
        v.z = pick_component();
        return v;
    endfunction

    function automatic logic signed [QUAT_W-1:0] pick_corner();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    // Kind 0: raw register contents; kind 1: corner values; else a unit quaternion.
    function automatic quat_t random_quat(input int kind);
        quat_t q;
        real   c [4];
        real   n;
        if (kind == 0) begin
            q = {QUAT_W'($urandom()), QUAT_W'($urandom()), QUAT_W'($urandom()),
                 QUAT_W'($urandom())};
        end else if (kind == 1) begin
            q = {pick_corner(), pick_corner(), pick_corner(), pick_corner()};
        end else begin
            do begin
                n = 0.0;
                for (int i = 0; i < 4; i++) begin
                    c[i] = real'($urandom_range(0, 2000)) - 1000.0;
                    n = n + c[i] * c[i];
                end
                n = $sqrt(n);
            end while (n < 1.0);
            q.w = QUAT_W'($rtoi(c[0] / n * Q_ONE));
            q.x = QUAT_W'($rtoi(c[1] / n * Q_ONE));
            q.y = QUAT_W'($rtoi(c[2] / n * Q_ONE));
            q.z = QUAT_W'($rtoi(c[3] / n * Q_ONE));
        end
        return q;
    endfunction

    task automatic write_quat_reg(input cfg_idx_t idx, input logic signed [QUAT_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    // Load a new quaternion: drop valid, let the pipeline empty, then write all
    // four registers on consecutive cycles.
    task automatic load_quat(input quat_t q);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_rot.size() != 0) @(posedge aclk);
        write_quat_reg(CFG_QUAT_W, q.w);
        write_quat_reg(CFG_QUAT_X, q.x);
        write_quat_reg(CFG_QUAT_Y, q.y);
        write_quat_reg(CFG_QUAT_Z, q.z);
        quat_cur = q;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one request after a random gap and hold it until accepted; record
    // the result it owes at the accepting edge.
    task automatic send_vec(input vec_t v, input rot_t want);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_vec_x <= v.x;
        s_vec_y <= v.y;
        s_vec_z <= v.z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rot.push_back(want);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Receiver: drive m_ready on the falling edge. A long hold-off, once asked,
    // keeps m_ready low so the pipeline fills and s_ready drops while the sender
    // keeps offering requests.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && stall_granted != stall_asked) begin
                stall_granted++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Compare every accepted result with the oldest owed one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_rot = {m_rot_x, m_rot_y, m_rot_z, m_saturated};
            if (pending_rot.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with no request pending, expected none, actual %0d %0d %0d sat %0d",
                             $time, m_rot_x, m_rot_y, m_rot_z, m_saturated);
            end else begin
                want_rot = pending_rot.pop_front();
                check_field("rot_x", want_rot.x, got_rot.x);
                check_field("rot_y", want_rot.y, got_rot.y);
                check_field("rot_z", want_rot.z, got_rot.z);
                check_field("saturated", want_rot.sat, got_rot.sat);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        dir_row_t row;
        quat_t    row_quat;
        vec_t     v;
        rot_t     want;

        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_QUAT_W;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_vec_x   = '0;
        s_vec_y   = '0;
        s_vec_z   = '0;
        // reset value of the quaternion registers: identity
        quat_cur  = {QUAT_W'(Q_ONE), QUAT_W'(0), QUAT_W'(0), QUAT_W'(0)};

        // Sender rarely idles, receiver mostly stalls for the directed part
        // and the first random phase.
        src_idle_pct  = 8;
        sink_idle_pct = 72;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: reload the quaternion only when a row changes it, so
        // the leading rows see the reset value.
        for (int i = 0; i < NUM_DIR; i++) begin
            row = DIR_ROWS[i];
            row_quat = {row.qw, row.qx, row.qy, row.qz};
            if (row_quat != quat_cur) load_quat(row_quat);
            v = {row.vx, row.vy, row.vz};
            if (row.typed) want = {row.ex, row.ey, row.ez, row.esat};
            else want = rotate_by_quat(v, quat_cur);
            send_vec(v, want);
        end

        // Random part: three idling phases, each walking several quaternions.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct  = 8;
                    sink_idle_pct = 72;
                end
                1: begin
                    src_idle_pct  = 72;
                    sink_idle_pct = 8;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 6; blk++) begin
                load_quat(random_quat(blk % 4));
                // hold off the receiver early in each of the first two phases
                if (blk == 0 && ph != 2) stall_asked++;
                for (int n = 0; n < BLOCK_ITEMS; n++) begin
                    v = random_vec();
                    send_vec(v, rotate_by_quat(v, quat_cur));
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_rot.size() != 0) @(posedge aclk);
        // catch any stray result trailing the last one
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/qvr_pkg.sv
hdl/qvr_rsat.sv
hdl/quaternion_vector_rotate_top.sv
tb/tb_quaternion_vector_rotate_top.sv
